>>> design/gsp_pkg.sv
// shared constants, types and the arctangent table for the gaze to sphere pixel unit
package gsp_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int VEC_W = 34;
    localparam int ANG_W = 27;

    localparam logic signed [ANG_W-1:0] ANG_180  = 27'sd11796480;
    localparam logic signed [19:0]      AZ_HALF  = 20'sd46080;
    localparam logic signed [19:0]      EL_HALF  = 20'sd23040;
    localparam logic [15:0]             INV_GAIN = 16'd39797;
    // ceil(2^25 / 45), exact floor division for 19 bit operands
    localparam logic [19:0]             RECIP_45 = 20'd745655;

    localparam logic [21:0] ATAN_TAB [0:23] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    typedef enum logic [1:0] {
        AZ_CORDIC = 2'd0,
        AZ_ZERO   = 2'd1,
        AZ_HALF_M = 2'd2
    } az_mode_t;

    localparam logic CMD_GAZE = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic                    cmd;
        az_mode_t                mode;
        logic                    gx_neg;
        logic                    gy_pos;
        logic signed [VEC_W-1:0] gz;
        logic signed [16:0]      az;
        logic signed [15:0]      el1;
        logic                    ezero;
    } side_t;

endpackage

>>> design/gaze_to_sphere_pixel_unit.sv
// gaze vector to sphere map pixel, two pipelined vectoring cordics and pixel mapping
// result path: input register, azimuth cordic, gain removal, elevation cordic, scale, divide, output
// throughput: one item per cycle while the output is not stalled, set by one register stage per cordic iteration
// a stalled output holds the whole pipeline; nothing is dropped or repeated
// reset: async active low, clears all valid bits, width 800 and height 600
// config registers are written with cfg_valid and cfg_ready, ready always high
module gaze_to_sphere_pixel_unit
    import gsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // rot_m00, rot_m10, rot_m20, az_in, el_in, zero pad
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // azimuth_out, elevation_out, pixel_x, pixel_y, clamped, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int N = CORDIC_STEPS;

    logic        en;
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd800;
            height_reg <= 13'd600;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // input prep
    logic signed [17:0]      m00, m10, m20;
    logic signed [16:0]      az_in;
    logic signed [15:0]      el_in;
    logic signed [VEC_W-1:0] gx, gy, gz;
    side_t                   side_in;

    assign m00   = $signed(s_tdata[17:0]);
    assign m10   = $signed(s_tdata[35:18]);
    assign m20   = $signed(s_tdata[53:36]);
    assign az_in = $signed(s_tdata[70:54]);
    assign el_in = $signed(s_tdata[86:71]);
    assign gx    = (-VEC_W'(m10)) <<< 12;
    assign gy    = (-VEC_W'(m20)) <<< 12;
    assign gz    = VEC_W'(m00) <<< 12;

    always_comb
    begin
        side_in.cmd    = s_tuser;
        side_in.gx_neg = gx[VEC_W-1];
        side_in.gy_pos = !gy[VEC_W-1] && (gy != '0);
        side_in.gz     = gz;
        side_in.ezero  = 1'b0;
        if (m10 == '0 && m20 == '0)
            side_in.mode = AZ_ZERO;
        else if (m20 == '0 && gx[VEC_W-1])
            side_in.mode = AZ_HALF_M;
        else
            side_in.mode = AZ_CORDIC;
        // negation of the most negative code saturates
        if (az_in == 17'sh10000)
            side_in.az = 17'sh0FFFF;
        else
            side_in.az = -az_in;
        if (el_in == 16'sh8000)
            side_in.el1 = 16'sh7FFF;
        else
            side_in.el1 = -el_in;
    end

    // first cordic: azimuth and magnitude
    logic signed [VEC_W-1:0] ax_reg [0:N];
    logic signed [VEC_W-1:0] ay_reg [0:N];
    logic signed [ANG_W-1:0] aa_reg [0:N];
    side_t                   as_reg [0:N];
    logic                    av_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            av_reg[0] <= 1'b0;
        else if (en)
            av_reg[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg[0] <= gx[VEC_W-1] ? -gx : gx;
            ay_reg[0] <= gx[VEC_W-1] ? -gy : gy;
            aa_reg[0] <= '0;
            as_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cordic_a
        logic signed [VEC_W-1:0] xs, ys;
        assign xs = ax_reg[i] >>> i;
        assign ys = ay_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                av_reg[i+1] <= 1'b0;
            else if (en)
                av_reg[i+1] <= av_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                as_reg[i+1] <= as_reg[i];
                if (!ay_reg[i][VEC_W-1])
                begin
                    ax_reg[i+1] <= ax_reg[i] + ys;
                    ay_reg[i+1] <= ay_reg[i] - xs;
                    aa_reg[i+1] <= aa_reg[i] + ANG_W'(ATAN_TAB[i]);
                end
                else
                begin
                    ax_reg[i+1] <= ax_reg[i] - ys;
                    ay_reg[i+1] <= ay_reg[i] + xs;
                    aa_reg[i+1] <= aa_reg[i] - ANG_W'(ATAN_TAB[i]);
                end
            end
        end
    end

    // gain removal
    logic [48:0]             mprod_reg;
    logic signed [ANG_W-1:0] mang_reg;
    side_t                   mside_reg;
    logic                    mv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (en)
            mv_reg <= av_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mprod_reg <= 49'(ax_reg[N][32:0]) * 49'(INV_GAIN) + 49'd32768;
            mang_reg  <= aa_reg[N];
            mside_reg <= as_reg[N];
        end
    end

    // azimuth finish and second cordic start
    logic signed [ANG_W-1:0] th;
    logic signed [18:0]      az_deg;
    logic signed [19:0]      az_neg;
    logic signed [16:0]      az_fin;
    logic [32:0]             r_val;
    side_t                   side_r;

    assign r_val  = mprod_reg[48:16];
    assign az_deg = 19'((th + 27'sd128) >>> 8);
    assign az_neg = -20'(az_deg);

    always_comb
    begin
        th = mang_reg;
        if (mside_reg.gx_neg)
            th = mside_reg.gy_pos ? mang_reg + ANG_180 : mang_reg - ANG_180;
        if (az_neg > AZ_HALF)
            az_fin = 17'(AZ_HALF);
        else if (az_neg < -AZ_HALF)
            az_fin = 17'(-AZ_HALF);
        else
            az_fin = 17'(az_neg);
        side_r       = mside_reg;
        side_r.ezero = (r_val == '0) && (mside_reg.gz == '0);
        if (mside_reg.cmd == CMD_GAZE)
        begin
            unique case (mside_reg.mode)
                AZ_ZERO:   side_r.az = '0;
                AZ_HALF_M: side_r.az = 17'(AZ_HALF);
                default:   side_r.az = az_fin;
            endcase
        end
    end

    logic signed [VEC_W-1:0] bx_reg [0:N];
    logic signed [VEC_W-1:0] by_reg [0:N];
    logic signed [ANG_W-1:0] ba_reg [0:N];
    side_t                   bs_reg [0:N];
    logic                    bv_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bv_reg[0] <= 1'b0;
        else if (en)
            bv_reg[0] <= mv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bx_reg[0] <= $signed({1'b0, r_val});
            by_reg[0] <= mside_reg.gz;
            ba_reg[0] <= '0;
            bs_reg[0] <= side_r;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cordic_b
        logic signed [VEC_W-1:0] xs, ys;
        assign xs = bx_reg[i] >>> i;
        assign ys = by_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                bv_reg[i+1] <= 1'b0;
            else if (en)
                bv_reg[i+1] <= bv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                bs_reg[i+1] <= bs_reg[i];
                if (!by_reg[i][VEC_W-1])
                begin
                    bx_reg[i+1] <= bx_reg[i] + ys;
                    by_reg[i+1] <= by_reg[i] - xs;
                    ba_reg[i+1] <= ba_reg[i] + ANG_W'(ATAN_TAB[i]);
                end
                else
                begin
                    bx_reg[i+1] <= bx_reg[i] - ys;
                    by_reg[i+1] <= by_reg[i] + xs;
                    ba_reg[i+1] <= ba_reg[i] - ANG_W'(ATAN_TAB[i]);
                end
            end
        end
    end

    // elevation finish and offset into map range
    logic signed [18:0] el_deg;
    logic signed [19:0] el_neg;
    logic signed [15:0] el_fin;
    logic signed [16:0] az_e_reg;
    logic signed [15:0] el_e_reg;
    logic signed [17:0] na_reg;
    logic signed [16:0] ne_reg;
    logic               ev_reg;

    assign el_deg = 19'((ba_reg[N] + 27'sd128) >>> 8);
    assign el_neg = -20'(el_deg);

    always_comb
    begin
        if (bs_reg[N].cmd == CMD_MAP)
            el_fin = bs_reg[N].el1;
        else if (bs_reg[N].ezero)
            el_fin = '0;
        else if (el_neg > EL_HALF)
            el_fin = 16'(EL_HALF);
        else if (el_neg < -EL_HALF)
            el_fin = 16'(-EL_HALF);
        else
            el_fin = 16'(el_neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_reg <= 1'b0;
        else if (en)
            ev_reg <= bv_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_e_reg <= bs_reg[N].az;
            el_e_reg <= el_fin;
            na_reg   <= 18'(bs_reg[N].az) + 18'(AZ_HALF);
            ne_reg   <= 17'(el_fin) + 17'(EL_HALF);
        end
    end

    // scale by map size
    logic signed [31:0] nx_reg, ny_reg;
    logic signed [16:0] az_q1_reg;
    logic signed [15:0] el_q1_reg;
    logic               q1v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q1v_reg <= 1'b0;
        else if (en)
            q1v_reg <= ev_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg    <= 32'($signed({1'b0, width_reg})) * 32'(na_reg);
            ny_reg    <= 32'($signed({1'b0, height_reg})) * 32'(ne_reg);
            az_q1_reg <= az_e_reg;
            el_q1_reg <= el_e_reg;
        end
    end

    // divide by span: shift out the power of two, reciprocal multiply by 45
    logic [38:0]        px_prod_reg, py_prod_reg;
    logic               negx_reg, negy_reg;
    logic signed [16:0] az_q2_reg;
    logic signed [15:0] el_q2_reg;
    logic               q2v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q2v_reg <= 1'b0;
        else if (en)
            q2v_reg <= q1v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_prod_reg <= 39'(nx_reg[29:11]) * 39'(RECIP_45);
            py_prod_reg <= 39'(ny_reg[28:10]) * 39'(RECIP_45);
            negx_reg    <= nx_reg[31];
            negy_reg    <= ny_reg[31];
            az_q2_reg   <= az_q1_reg;
            el_q2_reg   <= el_q1_reg;
        end
    end

    // clamp into image and output register
    logic [13:0] qx, qy;
    logic [12:0] upx, upy;
    logic [11:0] pix_x, pix_y;
    logic        clx, cly;

    assign qx  = px_prod_reg[38:25];
    assign qy  = py_prod_reg[38:25];
    assign upx = (width_reg > 13'd4096) ? 13'd4096 : width_reg;
    assign upy = (height_reg > 13'd4096) ? 13'd4096 : height_reg;

    always_comb
    begin
        clx   = 1'b0;
        pix_x = qx[11:0];
        if (negx_reg)
        begin
            clx   = 1'b1;
            pix_x = '0;
        end
        else if (qx >= 14'(upx))
        begin
            clx   = 1'b1;
            pix_x = (upx == '0) ? 12'd0 : 12'(upx - 13'd1);
        end
        cly   = 1'b0;
        pix_y = qy[11:0];
        if (negy_reg)
        begin
            cly   = 1'b1;
            pix_y = '0;
        end
        else if (qy >= 14'(upy))
        begin
            cly   = 1'b1;
            pix_y = (upy == '0) ? 12'd0 : 12'(upy - 13'd1);
        end
    end

    logic [63:0] out_reg;
    logic        ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= q2v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {6'd0, clx | cly, pix_y, pix_x, el_q2_reg, az_q2_reg};
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    // an unclamped result lies inside the configured image
    a_unclamped_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[57]) |->
            (13'(m_tdata[44:33]) < width_reg && 13'(m_tdata[56:45]) < height_reg))
        else $error("unclamped pixel outside image");

    // the first stage only fills from an accepted input item
    a_fill_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(av_reg[0]) |-> $past(s_tvalid && s_tready))
        else $error("pipeline valid without accepted item");

    // a stalled result is held
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

>>> verif/tb_gaze_to_sphere_pixel_unit.sv
// self-checking testbench for the gaze to sphere pixel unit
`timescale 1ns / 1ps

module tb_gaze_to_sphere_pixel_unit;
    import gsp_pkg::*;

    localparam int LATENCY   = 2 * CORDIC_STEPS + 7;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1200;
    localparam int N_DIRECT  = 22;
    localparam longint ARC_180 = 64'sd11796480;
    localparam logic [21:0] ARC_TAB [0:23] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    typedef struct packed {
        logic                cmd;
        logic signed [17:0]  m00;
        logic signed [17:0]  m10;
        logic signed [17:0]  m20;
        logic signed [16:0]  az;
        logic signed [15:0]  el;
    } gaze_in_t;

    typedef struct packed {
        logic signed [16:0] az;
        logic signed [15:0] el;
        logic [11:0]        px;
        logic [11:0]        py;
        logic               clamped;
    } pixel_t;

    typedef struct {
        gaze_in_t item;
        logic     known;
        pixel_t   res;
    } direct_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;

    gaze_to_sphere_pixel_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    int unsigned map_width;
    int unsigned map_height;
    pixel_t      pending_pixels[$];
    int          mismatches;
    int          wdog;
    bit          hold_long;
    bit          stall_mode;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint vector_angle(longint x, longint y, output longint mag);
        longint ang;
        longint xs;
        longint ys;
        ang = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                ang += ARC_TAB[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                ang -= ARC_TAB[i];
            end
        end
        mag = x;
        return ang;
    endfunction

    function automatic longint to_deg256(longint a);
        return div_floor(a + 128, 256);
    endfunction

    function automatic logic [11:0] place_pixel(longint ang, longint half, longint span,
                                                int unsigned size, inout logic flag);
        longint p;
        longint upper;
        p = div_floor(longint'(size) * (ang + half), span);
        upper = size > 4096 ? 4096 : size;
        if (p < 0)
        begin
            p = 0;
            flag = 1'b1;
        end
        else if (p >= upper)
        begin
            p = upper == 0 ? 0 : upper - 1;
            flag = 1'b1;
        end
        return p[11:0];
    endfunction

    function automatic pixel_t predict_pixel(gaze_in_t it);
        pixel_t r;
        longint az;
        longint el;
        longint gx;
        longint gy;
        longint gz;
        longint rk;
        longint rad;
        longint th;
        longint unused;
        logic   flag;
        flag = 1'b0;
        if (it.cmd == CMD_MAP)
        begin
            az = sat(-longint'(it.az), -65536, 65535);
            el = sat(-longint'(it.el), -32768, 32767);
        end
        else
        begin
            gx = -longint'(it.m10) * 4096;
            gy = -longint'(it.m20) * 4096;
            gz = longint'(it.m00) * 4096;
            rk = 0;
            if (gx == 0 && gy == 0)
                az = 0;
            else if (gy == 0 && gx < 0)
            begin
                az = 46080;
                th = vector_angle(-gx, 0, rk);
            end
            else
            begin
                if (gx < 0)
                begin
                    th = vector_angle(-gx, -gy, rk);
                    th += (gy > 0) ? ARC_180 : -ARC_180;
                end
                else
                    th = vector_angle(gx, gy, rk);
                az = sat(-to_deg256(th), -46080, 46080);
            end
            rad = (rk * 39797 + 32768) >>> 16;
            if (rad == 0 && gz == 0)
                el = 0;
            else
                el = sat(-to_deg256(vector_angle(rad, gz, unused)), -23040, 23040);
        end
        r.az = az[16:0];
        r.el = el[15:0];
        r.px = place_pixel(az, 46080, 92160, map_width, flag);
        r.py = place_pixel(el, 23040, 46080, map_height, flag);
        r.clamped = flag;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic gaze_in_t gaze_item(int m00, int m10, int m20);
        gaze_in_t g;
        g.cmd = CMD_GAZE;
        g.m00 = 18'(m00);
        g.m10 = 18'(m10);
        g.m20 = 18'(m20);
        g.az  = 17'($urandom);
        g.el  = 16'($urandom);
        return g;
    endfunction

    function automatic gaze_in_t map_item(int a, int e);
        gaze_in_t g;
        g.cmd = CMD_MAP;
        g.m00 = 18'($urandom);
        g.m10 = 18'($urandom);
        g.m20 = 18'($urandom);
        g.az  = 17'(a);
        g.el  = 16'(e);
        return g;
    endfunction

    function automatic int rand_q(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic gaze_in_t random_item();
        gaze_in_t g;
        int k;
        k = $urandom_range(9);
        if (k < 4)
            g = gaze_item(rand_q(65536), rand_q(65536), rand_q(65536));
        else if (k == 4)
            g = gaze_item(rand_q(3), rand_q(3), rand_q(3));
        else if (k == 5)
            g = gaze_item($urandom, $urandom, $urandom);
        else if (k < 8)
            g = map_item(rand_q(46080), rand_q(23040));
        else
            g = map_item($urandom, $urandom);
        return g;
    endfunction

    // compare against oldest expectation
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.az      = m_tdata[16:0];
            got.el      = m_tdata[32:17];
            got.px      = m_tdata[44:33];
            got.py      = m_tdata[56:45];
            got.clamped = m_tdata[57];
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected result item", 1, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (got.az !== want.az)
                    report_mismatch("azimuth_out", got.az, want.az);
                if (got.el !== want.el)
                    report_mismatch("elevation_out", got.el, want.el);
                if (got.px !== want.px)
                    report_mismatch("pixel_x", got.px, want.px);
                if (got.py !== want.py)
                    report_mismatch("pixel_y", got.py, want.py);
                if (got.clamped !== want.clamped)
                    report_mismatch("clamped", got.clamped, want.clamped);
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_long)
            m_tready <= 1'b0;
        else if (stall_mode)
            m_tready <= ($urandom_range(3) != 0);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("** gaze_to_sphere_pixel_unit: FAILED **");
            $finish;
        end
    end

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_WIDTH)
            map_width = 32'(val);
        else
            map_height = 32'(val);
    endtask

    task automatic send_item(gaze_in_t g);
        s_tvalid <= 1'b1;
        s_tuser  <= g.cmd;
        s_tdata  <= {1'b0, g.el, g.az, g.m20, g.m10, g.m00};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_pixels = {pending_pixels, predict_pixel(g)};
    endtask

    task automatic send_burst_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);
    endtask

    task automatic run_random(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(1))
                    send_burst_gap();
                burst = $urandom_range(1, 30);
            end
            send_item(random_item());
            burst--;
        end
        s_tvalid <= 1'b0;
    endtask

    direct_row_t directed[N_DIRECT];

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = 1'b0;
        cfg_data   = '0;
        hold_long  = 1'b0;
        stall_mode = 1'b0;
        mismatches = 0;
        wdog       = 0;
        map_width  = 800;
        map_height = 600;

        directed[0]  = '{gaze_item(0, 0, 0), 1'b1, '{17'sd0, 16'sd0, 12'd400, 12'd300, 1'b0}};
        directed[1]  = '{gaze_item(65536, 0, 0), 1'b1,
                         '{17'sd0, -16'sd23040, 12'd400, 12'd0, 1'b0}};
        directed[2]  = '{gaze_item(-65536, 0, 0), 1'b1,
                         '{17'sd0, 16'sd23040, 12'd400, 12'd599, 1'b1}};
        directed[3]  = '{gaze_item(0, 65536, 0), 1'b0, '0};
        directed[4]  = '{gaze_item(0, -65536, 0), 1'b0, '0};
        directed[5]  = '{gaze_item(0, 0, 65536), 1'b0, '0};
        directed[6]  = '{gaze_item(0, 0, -65536), 1'b0, '0};
        directed[7]  = '{gaze_item(-65536, -65536, -65536), 1'b0, '0};
        directed[8]  = '{gaze_item(65536, 65536, 65536), 1'b0, '0};
        directed[9]  = '{gaze_item(0, 65536, 1), 1'b0, '0};
        directed[10] = '{gaze_item(0, 65536, -1), 1'b0, '0};
        directed[11] = '{gaze_item(131071, -131072, 131071), 1'b0, '0};
        directed[12] = '{map_item(0, 0), 1'b1, '{17'sd0, 16'sd0, 12'd400, 12'd300, 1'b0}};
        directed[13] = '{map_item(46080, 23040), 1'b1,
                         '{-17'sd46080, -16'sd23040, 12'd0, 12'd0, 1'b0}};
        directed[14] = '{map_item(-46080, -23040), 1'b1,
                         '{17'sd46080, 16'sd23040, 12'd799, 12'd599, 1'b1}};
        directed[15] = '{map_item(-65536, -32768), 1'b1,
                         '{17'sd65535, 16'sd32767, 12'd799, 12'd599, 1'b1}};
        directed[16] = '{map_item(65535, 32767), 1'b1,
                         '{-17'sd65535, -16'sd32767, 12'd0, 12'd0, 1'b1}};
        directed[17] = '{map_item(-46079, 1), 1'b0, '0};
        directed[18] = '{map_item(-1, -1), 1'b0, '0};
        directed[19] = '{map_item(1, 1), 1'b0, '0};
        directed[20] = '{gaze_item(5, -3, 0), 1'b0, '0};
        directed[21] = '{gaze_item(1, 1, 1), 1'b0, '0};

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i].item);
            // typed-in value replaces the prediction for this row
            if (directed[i].known)
                pending_pixels[pending_pixels.size() - 1] = directed[i].res;
        end
        s_tvalid <= 1'b0;
        drain();

        // pipeline fill under long receiver hold-off
        stall_mode <= 1'b1;
        fork
            begin
                hold_long <= 1'b1;
                repeat (300)
                    @(posedge clk);
                hold_long <= 1'b0;
            end
            run_random(150);
        join
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_WIDTH, 13'd1);
                    write_reg(REG_HEIGHT, 13'd1);
                end
                1:
                begin
                    write_reg(REG_WIDTH, 13'd0);
                    write_reg(REG_HEIGHT, 13'd0);
                end
                2:
                begin
                    write_reg(REG_WIDTH, 13'd8191);
                    write_reg(REG_HEIGHT, 13'd8191);
                end
                3:
                begin
                    write_reg(REG_WIDTH, 13'd4096);
                    write_reg(REG_HEIGHT, 13'd4096);
                end
                4:
                begin
                    write_reg(REG_WIDTH, 13'($urandom_range(1, 4096)));
                    write_reg(REG_HEIGHT, 13'($urandom_range(1, 4096)));
                end
                default:
                begin
                    write_reg(REG_WIDTH, 13'd800);
                    write_reg(REG_HEIGHT, 13'd600);
                end
            endcase
            cfg_valid  <= 1'b0;
            stall_mode <= phase[0];
            run_random((N_RANDOM - 150) / 6);
            drain();
        end

        if (mismatches == 0)
            $display("** gaze_to_sphere_pixel_unit: PASSED **");
        else
            $display("** gaze_to_sphere_pixel_unit: FAILED **");
        $finish;
    end

endmodule
